// ----- rtl/mwvp_pkg.sv -----
package mwvp_pkg;

    localparam int WHEEL_W   = 2;
    localparam int SPEED_W   = 24;
    localparam int ERR_W     = 25;
    localparam int DIFF_W    = 26;
    localparam int SUM_W     = 40;
    localparam int GAIN_W    = 32;
    localparam int CMD_W     = 16;
    localparam int CFG_IDX_W = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_A      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_B      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_C      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_D      = 3'd6;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 32'd8388608;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 32'd83886;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 32'd0;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic [GAIN_W-1:0] prop;
        logic [GAIN_W-1:0] integ;
        logic [GAIN_W-1:0] deriv;
    } gains_t;

    // one entry of the per-wheel state memory
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic signed [ERR_W-1:0] last;
    } ent_t;

    // update stage to multiply pipeline
    typedef struct packed {
        logic [WHEEL_W-1:0]       wheel;
        logic signed [SUM_W-1:0]  sum;
        logic signed [DIFF_W-1:0] diff;
        logic signed [ERR_W-1:0]  err;
        logic                     clip;
    } upd_t;

    typedef struct packed {
        logic [WHEEL_W-1:0]      wheel;
        logic signed [CMD_W-1:0] cmd;
        logic                    clip;
    } result_t;

endpackage

// ----- rtl/mwvp_cfg_regs.sv -----
module mwvp_cfg_regs
    import mwvp_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [GAIN_W-1:0]           cfg_data,
    input  logic [WHEEL_W-1:0]          tgt_sel,
    output gains_t                      gains,
    output logic signed [SPEED_W-1:0]   tgt_speed
);

    logic [GAIN_W-1:0]         prop_reg;
    logic [GAIN_W-1:0]         integ_reg;
    logic [GAIN_W-1:0]         deriv_reg;
    logic signed [SPEED_W-1:0] tgt_reg [4];
    logic [CFG_IDX_W-1:0]      tgt_off;

    assign tgt_off = cfg_index - REG_TGT_A;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_reg  <= PROP_GAIN_RST;
            integ_reg <= INTEG_GAIN_RST;
            deriv_reg <= DERIV_GAIN_RST;
            for (int i = 0; i < 4; i++) begin
                tgt_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            unique case (cfg_index) inside
                REG_PROP_GAIN:  prop_reg  <= cfg_data;
                REG_INTEG_GAIN: integ_reg <= cfg_data;
                REG_DERIV_GAIN: deriv_reg <= cfg_data;
                REG_TGT_A, REG_TGT_B, REG_TGT_C, REG_TGT_D: begin
                    tgt_reg[tgt_off[1:0]] <= cfg_data[SPEED_W-1:0];
                end
                default: ;
            endcase
        end
    end

    assign gains.prop  = prop_reg;
    assign gains.integ = integ_reg;
    assign gains.deriv = deriv_reg;
    assign tgt_speed   = tgt_reg[tgt_sel];

endmodule

// ----- rtl/mwvp_state_ram.sv -----
module mwvp_state_ram
    import mwvp_pkg::*;
#(
    parameter int WHEELS = 4,
    localparam int IDX_W = (WHEELS > 1) ? $clog2(WHEELS) : 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    rd_en,
    input  logic [IDX_W-1:0]        rd_idx,
    input  logic                    wr_en,
    input  logic [IDX_W-1:0]        wr_idx,
    input  ent_t                    wr_ent,
    output ent_t                    rd_ent
);

    ent_t              mem [WHEELS];
    ent_t              rd_data_reg;
    logic [WHEELS-1:0] vld_reg;
    logic              rd_vld_reg;

    // read-first: a read at the written address returns the old entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_ent;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    // entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_idx] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_idx];
            end
        end
    end

    assign rd_ent = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ----- rtl/mwvp_math.sv -----
module mwvp_math
    import mwvp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     adv,
    input  logic     upd_v,
    input  upd_t     upd,
    input  gains_t   gains,
    output logic     out_v,
    output result_t  res
);

    localparam logic [71:0]        ITERM_LIMIT = 72'h1 << 61;
    localparam logic signed [63:0] POS_LIM     = 64'sd549755813888;
    localparam logic signed [63:0] NEG_LIM     = -64'sd549772591104;
    localparam logic signed [63:0] TRUNC_BIAS  = 64'sd16777215;

    // stage c: proportional and derivative products, integral magnitude
    logic                     c_v_reg;
    logic [WHEEL_W-1:0]       c_wheel_reg;
    logic                     c_clip_reg;
    logic                     c_neg_reg;
    logic [SUM_W-1:0]         c_mag_reg;
    logic signed [57:0]       c_p_reg;
    logic signed [58:0]       c_d_reg;
    logic [SUM_W-1:0]         c_mag_next;

    // stage d: integral partial products, p + d
    logic                     d_v_reg;
    logic [WHEEL_W-1:0]       d_wheel_reg;
    logic                     d_clip_reg;
    logic                     d_neg_reg;
    logic [51:0]              d_ph_reg;
    logic [51:0]              d_pl_reg;
    logic signed [59:0]       d_pd_reg;

    // stage e: full integral product
    logic                     e_v_reg;
    logic [WHEEL_W-1:0]       e_wheel_reg;
    logic                     e_clip_reg;
    logic                     e_neg_reg;
    logic [71:0]              e_full_reg;
    logic signed [59:0]       e_pd_reg;

    // stage f: clamped integral term
    logic                     f_v_reg;
    logic [WHEEL_W-1:0]       f_wheel_reg;
    logic                     f_clip_reg;
    logic                     f_neg_reg;
    logic [61:0]              f_imag_reg;
    logic signed [59:0]       f_pd_reg;

    // stage g: total in q.24
    logic                     g_v_reg;
    logic [WHEEL_W-1:0]       g_wheel_reg;
    logic                     g_clip_reg;
    logic signed [63:0]       g_total_reg;
    logic signed [63:0]       pd_ext;
    logic signed [63:0]       imag_ext;

    // output register
    logic                     o_v_reg;
    logic [WHEEL_W-1:0]       o_wheel_reg;
    logic                     o_clip_reg;
    logic signed [CMD_W-1:0]  o_cmd_reg;
    logic signed [CMD_W-1:0]  cmd_next;
    logic                     sat_next;
    logic signed [63:0]       round_next;

    assign c_mag_next = upd.sum[SUM_W-1] ? (~upd.sum + 40'd1) : upd.sum;
    assign pd_ext     = {{4{f_pd_reg[59]}}, f_pd_reg};
    assign imag_ext   = {2'b00, f_imag_reg};

    // truncation toward zero: bias negative totals before the arithmetic shift
    always_comb begin
        round_next = g_total_reg + (g_total_reg[63] ? TRUNC_BIAS : 64'sd0);
        if (g_total_reg >= POS_LIM) begin
            cmd_next = 16'sh7fff;
            sat_next = 1'b1;
        end else if (g_total_reg <= NEG_LIM) begin
            cmd_next = 16'sh8000;
            sat_next = 1'b1;
        end else begin
            cmd_next = round_next[39:24];
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end else if (adv) begin
            c_v_reg <= upd_v;
            d_v_reg <= c_v_reg;
            e_v_reg <= d_v_reg;
            f_v_reg <= e_v_reg;
            g_v_reg <= f_v_reg;
            o_v_reg <= g_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_wheel_reg <= upd.wheel;
            c_clip_reg  <= upd.clip;
            c_neg_reg   <= upd.sum[SUM_W-1];
            c_mag_reg   <= c_mag_next;
            c_p_reg     <= $signed({1'b0, gains.prop}) * upd.err;
            c_d_reg     <= $signed({1'b0, gains.deriv}) * upd.diff;

            d_wheel_reg <= c_wheel_reg;
            d_clip_reg  <= c_clip_reg;
            d_neg_reg   <= c_neg_reg;
            d_ph_reg    <= c_mag_reg[39:20] * gains.integ;
            d_pl_reg    <= c_mag_reg[19:0] * gains.integ;
            d_pd_reg    <= {{2{c_p_reg[57]}}, c_p_reg} + {c_d_reg[58], c_d_reg};

            e_wheel_reg <= d_wheel_reg;
            e_clip_reg  <= d_clip_reg;
            e_neg_reg   <= d_neg_reg;
            e_full_reg  <= {d_ph_reg, 20'd0} + {20'd0, d_pl_reg};
            e_pd_reg    <= d_pd_reg;

            f_wheel_reg <= e_wheel_reg;
            f_clip_reg  <= e_clip_reg;
            f_neg_reg   <= e_neg_reg;
            f_imag_reg  <= (e_full_reg > ITERM_LIMIT) ? ITERM_LIMIT[61:0] : e_full_reg[61:0];
            f_pd_reg    <= e_pd_reg;

            g_wheel_reg <= f_wheel_reg;
            g_clip_reg  <= f_clip_reg;
            g_total_reg <= f_neg_reg ? (pd_ext - imag_ext) : (pd_ext + imag_ext);

            o_wheel_reg <= g_wheel_reg;
            o_clip_reg  <= g_clip_reg | sat_next;
            o_cmd_reg   <= cmd_next;
        end
    end

    assign out_v     = o_v_reg;
    assign res.wheel = o_wheel_reg;
    assign res.cmd   = o_cmd_reg;
    assign res.clip  = o_clip_reg;

endmodule

// ----- rtl/multi_wheel_velocity_pid_unit.sv -----
// an input transfer reaches the m_ side through stages a and b, math stages c to g and the output register
// throughput: one sample per cycle; the eight-stage pipeline stalls as a whole on m_tready
// the per-wheel state read-modify-write takes one update stage, with forwarding from the
// previous write for back-to-back samples of the same wheel
// reset: synchronous, aresetn low clears the pipeline, the gains and targets to their
// defaults and the state valid bits, so every wheel starts with zero integral and error
module multi_wheel_velocity_pid_unit
    import mwvp_pkg::*;
#(
    parameter int WHEELS = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,    // [23:0] measured_speed
    input  logic [1:0]            s_tuser,    // [1:0] wheel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,    // [15:0] drive_cmd
    output logic [2:0]            m_tuser,    // [1:0] wheel_out, [2] clipped
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]           cfg_data
);

    localparam int IDX_W = (WHEELS > 1) ? $clog2(WHEELS) : 1;

    gains_t                     gains;
    logic signed [SPEED_W-1:0]  tgt_speed;
    logic                       adv;
    logic                       in_ok;
    logic signed [ERR_W-1:0]    err_next;

    logic                       a_v_reg;
    logic [WHEEL_W-1:0]         a_wheel_reg;
    logic signed [ERR_W-1:0]    a_err_reg;

    logic                       b_v_reg;
    logic [WHEEL_W-1:0]         b_wheel_reg;
    logic signed [ERR_W-1:0]    b_err_reg;
    logic                       fwd_reg;
    ent_t                       wb_ent_reg;

    ent_t                       rd_ent;
    ent_t                       op_ent;
    ent_t                       wr_ent;
    logic                       wr_en;
    logic signed [SUM_W:0]      sum_wide;
    logic signed [SUM_W-1:0]    sum_sat;
    logic                       sum_clip;
    logic signed [DIFF_W-1:0]   diff;
    upd_t                       upd;

    logic                       out_v;
    result_t                    res;

    assign adv       = !out_v || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    // samples for a wheel beyond the configured count are taken and dropped
    assign in_ok    = s_tvalid && ({1'b0, s_tuser} < 3'(WHEELS));
    assign err_next = {tgt_speed[SPEED_W-1], tgt_speed} - {s_tdata[SPEED_W-1], s_tdata};

    mwvp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tgt_sel   (s_tuser),
        .gains     (gains),
        .tgt_speed (tgt_speed)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            fwd_reg <= 1'b0;
        end else if (adv) begin
            a_v_reg <= in_ok;
            b_v_reg <= a_v_reg;
            // previous sample writes the same wheel in the cycle this one reads it
            fwd_reg <= b_v_reg && (b_wheel_reg == a_wheel_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_wheel_reg <= s_tuser;
            a_err_reg   <= err_next;
            b_wheel_reg <= a_wheel_reg;
            b_err_reg   <= a_err_reg;
            if (b_v_reg) begin
                wb_ent_reg <= wr_ent;
            end
        end
    end

    mwvp_state_ram #(
        .WHEELS (WHEELS)
    ) u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (adv && a_v_reg),
        .rd_idx  (a_wheel_reg[IDX_W-1:0]),
        .wr_en   (wr_en),
        .wr_idx  (b_wheel_reg[IDX_W-1:0]),
        .wr_ent  (wr_ent),
        .rd_ent  (rd_ent)
    );

    always_comb begin
        op_ent   = fwd_reg ? wb_ent_reg : rd_ent;
        sum_wide = {op_ent.sum[SUM_W-1], op_ent.sum}
                 + {{(SUM_W+1-ERR_W){b_err_reg[ERR_W-1]}}, b_err_reg};
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_sat  = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
            sum_clip = 1'b1;
        end else begin
            sum_sat  = sum_wide[SUM_W-1:0];
            sum_clip = 1'b0;
        end
        diff = {b_err_reg[ERR_W-1], b_err_reg} - {op_ent.last[ERR_W-1], op_ent.last};
    end

    assign wr_en       = adv && b_v_reg;
    assign wr_ent.sum  = sum_sat;
    assign wr_ent.last = b_err_reg;

    assign upd.wheel = b_wheel_reg;
    assign upd.sum   = sum_sat;
    assign upd.diff  = diff;
    assign upd.err   = b_err_reg;
    assign upd.clip  = sum_clip;

    mwvp_math u_math (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .upd_v   (b_v_reg),
        .upd     (upd),
        .gains   (gains),
        .out_v   (out_v),
        .res     (res)
    );

    assign m_tvalid = out_v;
    assign m_tdata  = res.cmd;
    assign m_tuser  = {res.clip, res.wheel};

endmodule

// ----- rtl/mwvp_checker.sv -----
module mwvp_checker #(
    parameter int WHEELS = 4
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // a stalled result holds until its transfer
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // the pipeline moves only when no result is waiting or the result side can take it
    a_ready_follows_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output backpressure");

    // results only for wheels that exist
    a_wheel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, m_tuser[1:0]} < 3'(WHEELS)))
        else $error("result for a wheel beyond the configured count");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind multi_wheel_velocity_pid_unit mwvp_checker #(.WHEELS(WHEELS)) u_mwvp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
